FILE: rtl/core/pmst_pkg.sv
package pmst_pkg;

    // Fixed field widths of the request and result channels.
    localparam int ROW_BITS       = 4;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int CFG_BITS       = 5;
    localparam int TOTAL_BITS     = 20;

    typedef logic [TOTAL_BITS-1:0] t_total;
    typedef logic [CFG_BITS-1:0]   t_vcount;

    // Running total saturates here.
    localparam t_total  TOTAL_MAX    = '1;
    localparam t_vcount VCOUNT_RESET = 5'd4;

endpackage

FILE: rtl/core/pmst_ram.sv
module pmst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port, single read port with the read data registered.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/prim_minimum_spanning_tree.sv
// Minimum spanning tree engine (Prim's algorithm over an adjacency matrix).
// The host loads the weighted adjacency matrix one entry per request, one
// request per cycle while ready; a weight of zero means there is no edge,
// and the host must write every entry that the run will read. The request
// with last set is stored like the others and then starts the tree build
// from vertex 0 over the first vertex_count vertices (the count is clamped
// to the range 2 to MAX_VERTICES). The input is not ready until the last
// result is taken. With n vertices the build takes up to (n-1) rounds of a
// minimum scan and a key relaxation; every key and matrix read goes through
// the registered read port of its memory and is judged by the one shared
// key comparator. Then one result per vertex 1 to n-1 is presented in order,
// each built in states REP_RD, REP_ADJ and REP_OUT and held until taken; a
// vertex that cannot be reached from vertex 0 is flagged disconnected with
// parent 0 and weight 0, and the running total saturates at its maximum.
// The vertex count register may be written at any time the engine is idle
// and is sampled when the last entry is accepted.
module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Matrix entry requests.
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [pmst_pkg::ROW_BITS-1:0]      i_row,
    input  logic [pmst_pkg::ROW_BITS-1:0]      i_col,
    input  logic [pmst_pkg::WEIGHT_IN_BITS-1:0] i_weight,
    input  logic                               i_last,
    // Tree edge results.
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pmst_pkg::ROW_BITS-1:0]      o_child_vertex,
    output logic [pmst_pkg::ROW_BITS-1:0]      o_parent_vertex,
    output logic [pmst_pkg::WEIGHT_IN_BITS-1:0] o_edge_weight,
    output logic [pmst_pkg::TOTAL_BITS-1:0]    o_total_distance,
    output logic                               o_disconnected,
    output logic                               o_end_of_tree,
    // Vertex count register write.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pmst_pkg::CFG_BITS-1:0]      i_cfg_vertex_count
);

    import pmst_pkg::*;

    // Vertex index width, key width (one extra bit encodes infinity) and the
    // width of the adder used for the running total.
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int KW = WEIGHT_BITS + 1;
    localparam int SW = ((WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS) + 1;
    localparam int ADJ_DEPTH = 1 << (2 * VW);
    localparam int KP_W = VW + WEIGHT_BITS;
    localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_EV  = 4'd2;
    localparam logic [3:0] S_RELAX_RD = 4'd3;
    localparam logic [3:0] S_RELAX_EV = 4'd4;
    localparam logic [3:0] S_REP_RD   = 4'd5;
    localparam logic [3:0] S_REP_ADJ  = 4'd6;
    localparam logic [3:0] S_REP_OUT  = 4'd7;
    localparam logic [3:0] S_REP_WAIT = 4'd8;

    logic [3:0]              r_state,     n_state;
    t_vcount                 r_vcount;
    logic [VW-1:0]           r_last_idx,  n_last_idx;
    logic [VW-1:0]           r_v,         n_v;
    logic [VW-1:0]           r_round,     n_round;
    logic [VW-1:0]           r_u,         n_u;
    logic [VW-1:0]           r_best,      n_best;
    logic [KW-1:0]           r_best_val,  n_best_val;
    logic                    r_found,     n_found;
    logic [MAX_VERTICES-1:0] r_in_tree,   n_in_tree;
    logic [MAX_VERTICES-1:0] r_kp_valid,  n_kp_valid;
    t_total                  r_total,     n_total;
    logic [VW-1:0]           r_par,       n_par;
    logic                    r_disc,      n_disc;

    logic                    r_out_valid, n_out_valid;
    logic [ROW_BITS-1:0]     r_out_child, n_out_child;
    logic [ROW_BITS-1:0]     r_out_par,   n_out_par;
    logic [WEIGHT_IN_BITS-1:0] r_out_w,   n_out_w;
    t_total                  r_out_total, n_out_total;
    logic                    r_out_disc,  n_out_disc;
    logic                    r_out_eot,   n_out_eot;

    // Memory ports.
    logic                    adj_wr_en;
    logic [2*VW-1:0]         adj_wr_addr;
    logic [WEIGHT_BITS-1:0]  adj_wr_data;
    logic [2*VW-1:0]         adj_rd_addr;
    logic [WEIGHT_BITS-1:0]  adj_rd_data;
    logic                    kp_wr_en;
    logic [VW-1:0]           kp_wr_addr;
    logic [KP_W-1:0]         kp_wr_data;
    logic [VW-1:0]           kp_rd_addr;
    logic [KP_W-1:0]         kp_rd_data;

    logic                    in_acc;
    logic                    entry_ok;
    logic [VW-1:0]           w_last_idx;
    logic [KW-1:0]           key_cur;
    logic [KW-1:0]           cmp_a;
    logic [KW-1:0]           cmp_b;
    logic                    cmp_lt;
    logic                    w_take;
    logic                    w_sel_found;
    logic [VW-1:0]           w_sel;
    logic [WEIGHT_BITS-1:0]  w_edge;
    logic [SW-1:0]           w_sum;
    t_total                  w_total_sat;

    assign in_acc   = i_valid && o_ready;
    assign entry_ok = (32'(i_row) < 32'(MAX_VERTICES)) && (32'(i_col) < 32'(MAX_VERTICES));

    // The adjacency matrix is stored row-major with a power-of-two row pitch.
    assign adj_wr_en   = in_acc && entry_ok;
    assign adj_wr_addr = {VW'(i_row), VW'(i_col)};
    assign adj_wr_data = WEIGHT_BITS'(i_weight);

    pmst_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (ADJ_DEPTH)
    ) u_adj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (adj_wr_en),
        .i_wr_addr (adj_wr_addr),
        .i_wr_data (adj_wr_data),
        .i_rd_addr (adj_rd_addr),
        .o_rd_data (adj_rd_data)
    );

    // Per-vertex key and parent. A clear valid bit reads as an infinite key
    // with parent 0; a new run clears the valid bits and writes only vertex 0.
    pmst_ram #(
        .WIDTH (KP_W),
        .DEPTH (MAX_VERTICES)
    ) u_kp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (kp_wr_en),
        .i_wr_addr (kp_wr_addr),
        .i_wr_data (kp_wr_data),
        .i_rd_addr (kp_rd_addr),
        .o_rd_data (kp_rd_data)
    );

    // Clamp the configured vertex count and keep the index of the last vertex.
    always_comb begin
        if (r_vcount < 5'd2) begin
            w_last_idx = VW'(1);
        end else if (32'(r_vcount) > 32'(MAX_VERTICES)) begin
            w_last_idx = VW'(MAX_VERTICES - 1);
        end else begin
            w_last_idx = VW'(r_vcount - 5'd1);
        end
    end

    // Key of the vertex read in the previous cycle.
    assign key_cur = r_kp_valid[r_v] ? {1'b0, kp_rd_data[WEIGHT_BITS-1:0]} : KEY_INF;

    // The shared comparator: key against the running minimum while scanning,
    // edge weight against the key while relaxing.
    always_comb begin
        if (r_state == S_RELAX_EV) begin
            cmp_a = {1'b0, adj_rd_data};
            cmp_b = key_cur;
        end else begin
            cmp_a = key_cur;
            cmp_b = r_best_val;
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    assign w_take      = !r_in_tree[r_v] && cmp_lt;
    assign w_sel_found = r_found || w_take;
    assign w_sel       = w_take ? r_v : r_best;

    // Running total with saturation.
    assign w_edge      = r_disc ? '0 : adj_rd_data;
    assign w_sum       = SW'(r_total) + SW'(w_edge);
    assign w_total_sat = (w_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : w_sum[TOTAL_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_last_idx  = r_last_idx;
        n_v         = r_v;
        n_round     = r_round;
        n_u         = r_u;
        n_best      = r_best;
        n_best_val  = r_best_val;
        n_found     = r_found;
        n_in_tree   = r_in_tree;
        n_kp_valid  = r_kp_valid;
        n_total     = r_total;
        n_par       = r_par;
        n_disc      = r_disc;
        n_out_valid = r_out_valid;
        n_out_child = r_out_child;
        n_out_par   = r_out_par;
        n_out_w     = r_out_w;
        n_out_total = r_out_total;
        n_out_disc  = r_out_disc;
        n_out_eot   = r_out_eot;
        kp_wr_en    = 1'b0;
        kp_wr_addr  = r_v;
        kp_wr_data  = {r_u, adj_rd_data};
        kp_rd_addr  = r_v;
        adj_rd_addr = {r_u, r_v};

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_last) begin
                    // Start a run: vertex 0 gets key 0, all others infinite.
                    n_last_idx = w_last_idx;
                    n_in_tree  = '0;
                    n_kp_valid = MAX_VERTICES'(1);
                    kp_wr_en   = 1'b1;
                    kp_wr_addr = '0;
                    kp_wr_data = '0;
                    n_total    = '0;
                    n_round    = '0;
                    n_v        = '0;
                    n_best_val = KEY_INF;
                    n_found    = 1'b0;
                    n_state    = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (r_v == r_last_idx) begin
                    if (!w_sel_found) begin
                        // No finite key left: the remaining vertices are unreachable.
                        n_v     = VW'(1);
                        n_state = S_REP_RD;
                    end else begin
                        n_u              = w_sel;
                        n_in_tree[w_sel] = 1'b1;
                        n_v              = '0;
                        n_state          = S_RELAX_RD;
                    end
                end else begin
                    n_best_val = w_take ? key_cur : r_best_val;
                    n_best     = w_sel;
                    n_found    = w_sel_found;
                    n_v        = r_v + VW'(1);
                    n_state    = S_SCAN_RD;
                end
            end
            S_RELAX_RD: begin
                n_state = S_RELAX_EV;
            end
            S_RELAX_EV: begin
                if ((adj_rd_data != '0) && !r_in_tree[r_v] && cmp_lt) begin
                    kp_wr_en        = 1'b1;
                    n_kp_valid[r_v] = 1'b1;
                end
                if (r_v == r_last_idx) begin
                    if (r_round == r_last_idx - VW'(1)) begin
                        n_v     = VW'(1);
                        n_state = S_REP_RD;
                    end else begin
                        n_round    = r_round + VW'(1);
                        n_v        = '0;
                        n_best_val = KEY_INF;
                        n_found    = 1'b0;
                        n_state    = S_SCAN_RD;
                    end
                end else begin
                    n_v     = r_v + VW'(1);
                    n_state = S_RELAX_RD;
                end
            end
            S_REP_RD: begin
                n_state = S_REP_ADJ;
            end
            S_REP_ADJ: begin
                // The parent comes straight from the key memory and addresses
                // the matrix entry [child][parent].
                adj_rd_addr = {r_v, kp_rd_data[KP_W-1:WEIGHT_BITS]};
                n_par       = r_kp_valid[r_v] ? kp_rd_data[KP_W-1:WEIGHT_BITS] : '0;
                n_disc      = !r_kp_valid[r_v];
                n_state     = S_REP_OUT;
            end
            S_REP_OUT: begin
                n_total     = r_disc ? r_total : w_total_sat;
                n_out_valid = 1'b1;
                n_out_child = ROW_BITS'(r_v);
                n_out_par   = ROW_BITS'(r_par);
                n_out_w     = WEIGHT_IN_BITS'(w_edge);
                n_out_total = r_disc ? r_total : w_total_sat;
                n_out_disc  = r_disc;
                n_out_eot   = (r_v == r_last_idx);
                n_state     = S_REP_WAIT;
            end
            S_REP_WAIT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_v == r_last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_v     = r_v + VW'(1);
                        n_state = S_REP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= VCOUNT_RESET;
            r_in_tree   <= '0;
            r_kp_valid  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_vertex_count;
            end
            r_in_tree   <= n_in_tree;
            r_kp_valid  <= n_kp_valid;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_idx  <= n_last_idx;
        r_v         <= n_v;
        r_round     <= n_round;
        r_u         <= n_u;
        r_best      <= n_best;
        r_best_val  <= n_best_val;
        r_found     <= n_found;
        r_par       <= n_par;
        r_disc      <= n_disc;
        r_out_child <= n_out_child;
        r_out_par   <= n_out_par;
        r_out_w     <= n_out_w;
        r_out_total <= n_out_total;
        r_out_disc  <= n_out_disc;
        r_out_eot   <= n_out_eot;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_child_vertex   = r_out_child;
    assign o_parent_vertex  = r_out_par;
    assign o_edge_weight    = r_out_w;
    assign o_total_distance = r_out_total;
    assign o_disconnected   = r_out_disc;
    assign o_end_of_tree    = r_out_eot;

    // A result is only presented while the sequencer waits for it to be taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_REP_WAIT))
        else $error("result valid outside the result wait state");

    // An unreachable vertex carries neither a parent nor a weight.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_disconnected) |-> ((o_edge_weight == '0) && (o_parent_vertex == '0)))
        else $error("disconnected result with parent or weight set");

    // The vertex whose neighbors are relaxed has already joined the tree.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX_RD) |-> r_in_tree[r_u])
        else $error("relaxing from a vertex outside the tree");

    // Within a run the running total never goes down.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_state != S_IDLE) && ($past(r_state) != S_IDLE))
            |-> (r_total >= $past(r_total)))
        else $error("running total decreased during a run");

endmodule
